>>> rtl/core/signed_int_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal text converter.
// Each macro expects signals named clock and reset in the using module.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SITDA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sitda assertion failed");

// next-cycle implication
`define SITDA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sitda assertion failed");

`else

`define SITDA_ASSERT_IMPL(label, ante, cons)
`define SITDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Types, character codes and the power-of-ten table for the decimal
// text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sitda_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 7;
   localparam int POS_W      = 4;
   localparam int WEIGHT_W   = 34;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

   typedef struct packed {
      logic load;
      logic count;
      logic emit_sign;
      logic emit_digit;
   } sitda_cmd_type;

   typedef struct packed {
      logic negative;
      logic pos_zero;
      logic out_free;
   } sitda_status_type;

   function automatic logic [VALUE_W-1:0] pow10(input logic [POS_W-1:0] pos);
      logic [VALUE_W-1:0] w;
      unique case (pos)
         4'd0:    w = 32'd1;
         4'd1:    w = 32'd10;
         4'd2:    w = 32'd100;
         4'd3:    w = 32'd1000;
         4'd4:    w = 32'd10000;
         4'd5:    w = 32'd100000;
         4'd6:    w = 32'd1000000;
         4'd7:    w = 32'd10000000;
         4'd8:    w = 32'd100000000;
         4'd9:    w = 32'd1000000000;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: accepts a value, runs the digit count, then steps the sign
// and digits out one per free output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitda_ctrl
   import sitda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sitda_status_type status,
   output sitda_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_COUNT = 2'd1;
   localparam logic [1:0] S_SIGN  = 2'd2;
   localparam logic [1:0] S_DIGIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = status.negative ? S_SIGN : S_DIGIT;
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.pos_zero) begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/sitda_datapath.sv
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude register, digit count, one-digit-per-cycle compare bank
// against the multiples of the current power of ten (held while the output register is not free), and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "signed_int_to_decimal_ascii_defines.svh"

module sitda_datapath
   import sitda_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  sitda_cmd_type        cmd,
   output sitda_status_type     status,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAR_W-1:0]    rsp_char_code,
   output logic                 rsp_is_last
);

   logic [VALUE_W-1:0] mag_ff,  mag_in;
   logic               neg_ff,  neg_in;
   logic [POS_W-1:0]   pos_ff,  pos_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [VALUE_W-1:0]  weight;
   logic [POS_W-1:0]    count_pos;
   logic [3:0]          digit;
   logic [WEIGHT_W-1:0] sub_val;
   logic                out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign weight   = pow10(pos_ff);

   // number of decimal places above the units digit
   always_comb begin
      count_pos = '0;
      for (int p = 1; p <= 9; p++) begin
         if (mag_ff >= pow10(POS_W'(p))) begin
            count_pos = POS_W'(p);
         end
      end
   end

   // leading digit at the current position
   always_comb begin
      digit   = '0;
      sub_val = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, mag_ff} >= WEIGHT_W'(k) * {2'b00, weight}) begin
            digit   = 4'(k);
            sub_val = WEIGHT_W'(k) * {2'b00, weight};
         end
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         neg_in = req_value[31];
         mag_in = req_value[31] ? (32'd0 - 32'(req_value)) : 32'(req_value);
      end
      if (cmd.count) begin
         pos_in = count_pos;
      end
      if (cmd.emit_sign) begin
         char_in  = CHAR_MINUS;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         char_in  = CHAR_ZERO + {3'b000, digit};
         last_in  = (pos_ff == '0);
         valid_in = 1'b1;
         mag_in   = mag_ff - sub_val[VALUE_W-1:0];
         pos_in   = pos_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.negative = neg_ff;
   assign status.pos_zero = (pos_ff == '0);
   assign status.out_free = out_free;

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_is_last   = last_ff;

   `SITDA_ASSERT_IMPL(a_emit_needs_slot, cmd.emit_sign || cmd.emit_digit, out_free)
   `SITDA_ASSERT_IMPL(a_sign_only_negative, cmd.emit_sign, neg_ff)
   `SITDA_ASSERT_NEXT(a_units_clears_mag, cmd.emit_digit && pos_ff == '0, mag_ff == '0)

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's complement integer to its decimal ASCII text,
// one character per rsp transaction, most significant first.
// ----------------------------------------------------------------------------
//  channel | direction | payload                  | handshake
//  req     | in        | value[31:0] signed       | req_valid / req_ready
//  rsp     | out       | char_code[6:0], is_last  | rsp_valid / rsp_ready
//
//  An item has N characters (1..11). Accepting it forms the magnitude, the
//  count state finds the number of digits, then the compare bank against the
//  multiples of 10^pos yields one character a cycle while rsp is not stalled.
//  Reset clears the sequencer and the output valid.
//  A stalled rsp holds the sequencer; a new req transaction is taken as soon as
//  the last character sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_char_code,
   output logic               rsp_is_last
);

   sitda_cmd_type    cmd;
   sitda_status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks signed_int_to_decimal_ascii. Values are converted to decimal text
// by a local predictor as each req transaction is accepted. Every rsp
// transaction is checked against the oldest expected character. Both sides
// idle at random, and before some items the sender pauses until all
// expected characters are back.
// ----------------------------------------------------------------------------

module testbench;
   import sitda_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned RANDOM_ITEMS  = 430;
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef struct {
      logic signed [31:0] value;
      int unsigned        gap;
      bit                 drain;
   } pending_value_type;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [6:0]         rsp_char_code;
   logic               rsp_is_last;

   pending_value_type pending_values[$];
   text_char_type     expected_chars[$];
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       chars_seen = 0;
   int unsigned       gap_left = 0;
   bit                gap_loaded = 1'b0;
   int unsigned       stall_left = 0;

   signed_int_to_decimal_ascii DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      error_count++;
   endtask

   // decimal text of one value, pushed onto the expected characters
   function automatic void push_decimal_text(input logic signed [31:0] value);
      logic [31:0]   mag;
      logic [3:0]    digits [10];
      int            ndig;
      text_char_type c;
      ndig = 0;
      mag = value[31] ? (32'd0 - value) : value;
      do begin
         digits[ndig] = 4'(mag % 10);
         mag = mag / 10;
         ndig++;
      end while (mag != 0);
      if (value[31]) begin
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
         c.code = CHAR_ZERO + digits[k];
         c.last = (k == 0);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic logic signed [31:0] random_value();
      logic [31:0] v;
      longint      p;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         v = $urandom();
      end else if (kind < 8) begin
         // spread over all digit counts
         v = $urandom() >> $urandom_range(0, 31);
         if ($urandom_range(0, 1)) v = 32'd0 - v;
      end else begin
         // around a power of ten
         p = 1;
         repeat ($urandom_range(0, 9)) p = p * 10;
         p = p + $signed($urandom_range(0, 2)) - 1;
         v = p[31:0];
         if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      return v;
   endfunction

   // sender
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            push_decimal_text(req_value);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_values.size() > 0) begin
            if (!gap_loaded) begin
               gap_left = pending_values[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!pending_values[0].drain || expected_chars.size() == 0) begin
               req_value <= pending_values[0].value;
               pending_values.pop_front();
               gap_loaded = 1'b0;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected char_code", 0, rsp_char_code);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code)
                  report_mismatch("char_code", want.code, rsp_char_code);
               if (rsp_is_last !== want.last)
                  report_mismatch("is_last", want.last, rsp_is_last);
            end
            stall_left = ((chars_seen % 300) < 80) ? 0 : $urandom_range(0, 16);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] directed [$];
      pending_value_type  item;
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                   32'sd100, -32'sd100, 32'sd2147483647, 32'h80000000,
                   -32'sd2147483647, 32'sd1000000000, 32'sd999999999,
                   -32'sd999999999, -32'sd1000000000, 32'h55555555, 32'hAAAAAAAA,
                   32'sd1234567890, -32'sd5, 32'sd7};
      foreach (directed[i]) begin
         item.value = directed[i];
         item.gap   = (i < 8) ? 0 : $urandom_range(0, 16);
         item.drain = (i == 10);
         pending_values.push_back(item);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         item.value = random_value();
         item.gap   = ((i % 100) < 20) ? 0 : $urandom_range(0, 16);
         item.drain = (i % 60 == 0);
         pending_values.push_back(item);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() > 0 || req_valid) @(posedge clock);
      while (expected_chars.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sitda_pkg.sv
rtl/core/sitda_ctrl.sv
rtl/core/sitda_datapath.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/testbench.sv
